// File: sv/ipsc_pkg.sv
// ----------------------------------------------------------------------------
// ipsc_pkg: shared types and constants of the incremental PID speed controller
// Holds the field widths, the register index codes, the direction codes and
// the structs that pass the gains, the loop state and one result between
// the top level and the datapath.
// ----------------------------------------------------------------------------
package ipsc_pkg;

    localparam int SpeedW  = 16;    // Q8.8 speed fields
    localparam int GainW   = 16;    // Q8.8 unsigned gains
    localparam int DutyW   = 14;    // duty, offset and limit
    localparam int ErrW    = 18;    // signed error after sign folding
    localparam int DriveW  = 16;    // signed drive kept between samples
    localparam int DirW    = 2;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    // Reset values of the configuration registers.
    localparam logic [GainW-1:0] GainPropReset    = 16'd5120;
    localparam logic [GainW-1:0] GainIntegReset   = 16'd1280;
    localparam logic [GainW-1:0] GainDerivReset   = 16'd0;
    localparam logic [DutyW-1:0] DriveOffsetReset = 14'd1300;
    localparam logic [DutyW-1:0] DutyLimitReset   = 14'd10000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAIN_PROP    = 3'd0,
        REG_GAIN_INTEG   = 3'd1,
        REG_GAIN_DERIV   = 3'd2,
        REG_DRIVE_OFFSET = 3'd3,
        REG_DUTY_LIMIT   = 3'd4
    } cfg_reg_t;

    localparam logic [DirW-1:0] DIR_CW   = 2'd0;
    localparam logic [DirW-1:0] DIR_CCW  = 2'd1;
    localparam logic [DirW-1:0] DIR_STOP = 2'd2;

    typedef struct packed {
        logic [GainW-1:0] gain_prop;
        logic [GainW-1:0] gain_integ;
        logic [GainW-1:0] gain_deriv;
        logic [DutyW-1:0] drive_offset;
        logic [DutyW-1:0] duty_limit;
    } ipsc_cfg_t;

    typedef struct packed {
        logic signed [ErrW-1:0]   last_error;
        logic signed [ErrW-1:0]   older_error;
        logic signed [DriveW-1:0] prior_drive;
    } ipsc_state_t;

    typedef struct packed {
        logic [DutyW-1:0] duty;
        logic [DirW-1:0]  turn_dir;
    } ipsc_result_t;

endpackage

// File: sv/ipsc_datapath.sv
// ----------------------------------------------------------------------------
// ipsc_datapath: one control step of the velocity-form PID
// Folds the request sign, forms the error, sums the three gain products,
// truncates toward zero to duty units, adds drive and offset and clamps.
// ----------------------------------------------------------------------------
module ipsc_datapath
    import ipsc_pkg::*;
(
    input  logic signed [SpeedW-1:0] speed_request,
    input  logic signed [SpeedW-1:0] speed_measured,
    input  ipsc_cfg_t                cfg,
    input  ipsc_state_t              state,
    output ipsc_state_t              state_next,
    output ipsc_result_t             result
);

    localparam int KW   = GainW + 2;          // sum of up to three gains
    localparam int PW   = KW + 1 + ErrW;      // product width
    localparam int AccW = PW + 3;
    localparam int DW   = AccW - 16;          // integer part of the sum
    localparam int SumW = DW + 2;

    logic                     req_neg;
    logic                     req_zero;
    logic signed [SpeedW:0]   req_abs;
    logic signed [SpeedW:0]   vel_fold;
    logic signed [ErrW-1:0]   err;
    logic        [KW-1:0]     k_a;
    logic        [KW-1:0]     k_b;
    logic signed [PW-1:0]     prod_a;
    logic signed [PW-1:0]     prod_b;
    logic signed [PW-1:0]     prod_c;
    logic signed [AccW-1:0]   acc;
    logic signed [DW-1:0]     delta;
    logic signed [SumW-1:0]   sum;
    logic        [DutyW-1:0]  duty_clamped;

    assign req_neg  = speed_request[SpeedW-1];
    assign req_zero = (speed_request == '0);

    // Negating in one extra bit keeps a request of the most negative value exact.
    always_comb
    begin
        if (req_neg)
        begin
            req_abs  = -(SpeedW+1)'(speed_request);
            vel_fold = -(SpeedW+1)'(speed_measured);
        end
        else
        begin
            req_abs  = (SpeedW+1)'(speed_request);
            vel_fold = (SpeedW+1)'(speed_measured);
        end
    end

    assign err = ErrW'(req_abs) - ErrW'(vel_fold);

    assign k_a = KW'(cfg.gain_prop) + KW'(cfg.gain_integ) + KW'(cfg.gain_deriv);
    assign k_b = KW'(cfg.gain_prop) + KW'({cfg.gain_deriv, 1'b0});

    assign prod_a = $signed({1'b0, k_a}) * err;
    assign prod_b = $signed({1'b0, k_b}) * state.last_error;
    assign prod_c = $signed({1'b0, cfg.gain_deriv}) * state.older_error;

    assign acc = AccW'(prod_a) - AccW'(prod_b) + AccW'(prod_c);

    // Arithmetic shift floors; a negative sum with a fraction moves up by one.
    assign delta = $signed(acc[AccW-1:16])
                 + DW'({1'b0, (acc[AccW-1] && (acc[15:0] != '0))});

    assign sum = SumW'(state.prior_drive) + SumW'(delta)
               + SumW'($signed({1'b0, cfg.drive_offset}));

    always_comb
    begin
        if (sum < 0)
            duty_clamped = '0;
        else if (sum > SumW'($signed({1'b0, cfg.duty_limit})))
            duty_clamped = cfg.duty_limit;
        else
            duty_clamped = sum[DutyW-1:0];
    end

    always_comb
    begin
        if (req_zero)
        begin
            state_next      = '0;
            result.duty     = '0;
            result.turn_dir = DIR_STOP;
        end
        else
        begin
            state_next.last_error  = err;
            state_next.older_error = state.last_error;
            state_next.prior_drive = $signed(DriveW'(duty_clamped))
                                   - $signed(DriveW'(cfg.drive_offset));
            result.duty            = duty_clamped;
            result.turn_dir        = req_neg ? DIR_CCW : DIR_CW;
        end
    end

endmodule

// File: sv/incremental_pid_speed_controller.sv
// ----------------------------------------------------------------------------
// incremental_pid_speed_controller: velocity-form PID for one motor
// Takes one speed sample per control period and returns the PWM duty and
// the turning direction, with gains, offset and limit set by register writes.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Word
//  -------   ---------------------   -------------------------------------
//  input     in_valid / in_ready     speed_request, speed_measured (Q8.8)
//  output    out_valid / out_ready   duty, turn_dir
//  config    cfg_wr_en               cfg_index, cfg_wdata (write only)
//
//  A word passes from the input register through the datapath into the output
//  register, one word per cycle sustained while the output is not stalled.
//  The cycle is set by the error products and the clamp between the input
//  register and the output register. Reset clears the pipeline valids and
//  the loop state and loads the register defaults. A stalled output holds its
//  word; the input register still takes a new word while it is empty.
// ----------------------------------------------------------------------------
module incremental_pid_speed_controller
    import ipsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [SpeedW-1:0]  speed_request,
    input  logic signed [SpeedW-1:0]  speed_measured,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic        [DutyW-1:0]   duty,
    output logic        [DirW-1:0]    turn_dir,
    input  logic                      cfg_wr_en,
    input  logic        [CfgIdxW-1:0] cfg_index,
    input  logic        [CfgDatW-1:0] cfg_wdata
);

    ipsc_cfg_t                cfg_reg;
    ipsc_state_t              state_reg;
    ipsc_state_t              state_next;
    ipsc_result_t             result_next;
    logic                     s1_valid_reg;
    logic signed [SpeedW-1:0] s1_req_reg;
    logic signed [SpeedW-1:0] s1_meas_reg;
    logic                     out_valid_reg;
    ipsc_result_t             out_word_reg;
    logic                     out_free;
    logic                     s1_fire;
    logic                     in_fire;

    // The output register can take a word when it is empty or being read.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    // Configuration registers. Unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop    <= GainPropReset;
            cfg_reg.gain_integ   <= GainIntegReset;
            cfg_reg.gain_deriv   <= GainDerivReset;
            cfg_reg.drive_offset <= DriveOffsetReset;
            cfg_reg.duty_limit   <= DutyLimitReset;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GAIN_PROP:    cfg_reg.gain_prop    <= cfg_wdata;
                REG_GAIN_INTEG:   cfg_reg.gain_integ   <= cfg_wdata;
                REG_GAIN_DERIV:   cfg_reg.gain_deriv   <= cfg_wdata;
                REG_DRIVE_OFFSET: cfg_reg.drive_offset <= cfg_wdata[DutyW-1:0];
                REG_DUTY_LIMIT:   cfg_reg.duty_limit   <= cfg_wdata[DutyW-1:0];
                default:          ;
            endcase
        end
    end

    // The datapath sees the word in the input register and the loop state;
    // the state moves only when that word is handed to the output register,
    // so back-to-back words always see the result of their predecessor.
    ipsc_datapath u_datapath (
        .speed_request  (s1_req_reg),
        .speed_measured (s1_meas_reg),
        .cfg            (cfg_reg),
        .state          (state_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (s1_fire)
                state_reg <= state_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg  <= speed_request;
            s1_meas_reg <= speed_measured;
        end
        if (s1_fire)
            out_word_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign duty      = out_word_reg.duty;
    assign turn_dir  = out_word_reg.turn_dir;

`ifndef NO_ASSERTIONS
    // A stop word always leaves the motor without drive.
    a_stop_no_duty : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && turn_dir == DIR_STOP) |-> (duty == '0))
        else $error("stop word carries a nonzero duty");

    // The clamp never lets the duty pass the configured limit.
    a_duty_limit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty <= cfg_reg.duty_limit))
        else $error("duty above duty_limit");

    // A zero request clears the loop history for the next sample.
    a_stop_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_req_reg == '0) |=>
            (state_reg.last_error == '0 && state_reg.older_error == '0 &&
             state_reg.prior_drive == '0))
        else $error("loop state not cleared by a zero request");

    // Loop state changes only when a word moves into the output register.
    a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(state_reg))
        else $error("loop state changed without a word");
`endif

endmodule

// File: tb/duty_checker.sv
// ----------------------------------------------------------------------------
// duty_checker: prediction and comparison for the PID speed controller
// Watches the register port and both word channels, keeps its own copy of
// the gains and the loop state, predicts the duty and direction of every
// accepted sample and compares them with the words the block hands out.
// ----------------------------------------------------------------------------
module duty_checker
    import ipsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [SpeedW-1:0]  speed_request,
    input  logic signed [SpeedW-1:0]  speed_measured,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic        [DutyW-1:0]   duty,
    input  logic        [DirW-1:0]    turn_dir,
    input  logic                      cfg_wr_en,
    input  logic        [CfgIdxW-1:0] cfg_index,
    input  logic        [CfgDatW-1:0] cfg_wdata,
    output int                        mismatch_count,
    output int                        words_in_flight
);

    localparam longint FracScale = 65536;

    ipsc_cfg_t                settings;
    logic signed [ErrW-1:0]   last_err;
    logic signed [ErrW-1:0]   older_err;
    logic signed [DriveW-1:0] held_drive;
    ipsc_result_t             expected_drive[$];

    // Velocity-form update: the new duty follows from the error history and
    // the drive kept from the previous sample.
    function automatic ipsc_result_t predict_drive(logic signed [SpeedW-1:0] req_in,
                                                   logic signed [SpeedW-1:0] meas_in);
        ipsc_result_t    want;
        int              req;
        int              vel;
        int              err;
        longint          kp;
        longint          ki;
        longint          kd;
        longint          e1;
        longint          e2;
        longint          acc;
        longint          total;
        req = int'(req_in);
        vel = int'(meas_in);
        kp  = longint'(settings.gain_prop);
        ki  = longint'(settings.gain_integ);
        kd  = longint'(settings.gain_deriv);
        if (req == 0) begin
            last_err      = '0;
            older_err     = '0;
            held_drive    = '0;
            want.duty     = '0;
            want.turn_dir = DIR_STOP;
            return want;
        end
        if (req < 0) begin
            req           = -req;
            vel           = -vel;
            want.turn_dir = DIR_CCW;
        end else begin
            want.turn_dir = DIR_CW;
        end
        err   = req - vel;
        e1    = longint'(last_err);
        e2    = longint'(older_err);
        acc   = (kp + ki + kd) * longint'(err) - (kp + 2 * kd) * e1 + kd * e2;
        total = longint'(held_drive) + acc / FracScale + longint'(settings.drive_offset);
        if (total > longint'(settings.duty_limit))
            total = longint'(settings.duty_limit);
        if (total < 0)
            total = 0;
        want.duty  = total[DutyW-1:0];
        held_drive = DriveW'(total - longint'(settings.drive_offset));
        older_err  = last_err;
        last_err   = ErrW'(err);
        return want;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        ipsc_result_t want;
        if (!rst_n) begin
            settings.gain_prop    = GainPropReset;
            settings.gain_integ   = GainIntegReset;
            settings.gain_deriv   = GainDerivReset;
            settings.drive_offset = DriveOffsetReset;
            settings.duty_limit   = DutyLimitReset;
            last_err              = '0;
            older_err             = '0;
            held_drive            = '0;
            expected_drive.delete();
            mismatch_count        = 0;
            words_in_flight       = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_drive.size() == 0) begin
                    $error("output word with no prediction waiting: duty %0d, turn_dir %0d",
                           duty, turn_dir);
                    mismatch_count++;
                end else begin
                    want = expected_drive.pop_front();
                    if (duty !== want.duty) begin
                        $error("duty: expected %0d, actual %0d", want.duty, duty);
                        mismatch_count++;
                    end
                    if (turn_dir !== want.turn_dir) begin
                        $error("turn_dir: expected %0d, actual %0d", want.turn_dir, turn_dir);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GAIN_PROP:    settings.gain_prop    = cfg_wdata;
                    REG_GAIN_INTEG:   settings.gain_integ   = cfg_wdata;
                    REG_GAIN_DERIV:   settings.gain_deriv   = cfg_wdata;
                    REG_DRIVE_OFFSET: settings.drive_offset = cfg_wdata[DutyW-1:0];
                    REG_DUTY_LIMIT:   settings.duty_limit   = cfg_wdata[DutyW-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                expected_drive.push_back(predict_drive(speed_request, speed_measured));
            words_in_flight = expected_drive.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the incremental PID speed controller
// Runs a directed part over the field extremes and the special cases, then
// phases of random motor trajectories under random register settings, with
// idling on both channels. The checker beside the block predicts and
// compares; this module only drives words and reports the outcome.
// ----------------------------------------------------------------------------
module tb;
    import ipsc_pkg::*;

    // Cycles without any handshake or register write before the run is
    // declared hung. Bursts of idling stay far below this limit.
    localparam int WatchLimit    = 2000;
    localparam int PhaseCount    = 8;
    localparam int PhaseWords    = 100;
    localparam int DrainCycles   = 8;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [SpeedW-1:0]  speed_request;
    logic signed [SpeedW-1:0]  speed_measured;
    logic                      out_valid;
    logic                      out_ready;
    logic        [DutyW-1:0]   duty;
    logic        [DirW-1:0]    turn_dir;
    logic                      cfg_wr_en;
    logic        [CfgIdxW-1:0] cfg_index;
    logic        [CfgDatW-1:0] cfg_wdata;

    int mismatch_count;
    int words_in_flight;
    int idle_cycles;

    // Percent chance that a burst of idling starts on the input side after
    // a word, and on the output side at any cycle. Zero means no idling.
    int gap_pct;
    int stall_pct;
    int stall_left;

    incremental_pid_speed_controller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .speed_request  (speed_request),
        .speed_measured (speed_measured),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .duty           (duty),
        .turn_dir       (turn_dir),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    duty_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .speed_request   (speed_request),
        .speed_measured  (speed_measured),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .duty            (duty),
        .turn_dir        (turn_dir),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver drops ready in random bursts. Ready only
    // changes at the falling edge, once per cycle.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Any handshake or register write counts as progress. The handshake
    // signals are read at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WatchLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one sample word and holds it until it is taken. Valid stays
    // high afterwards unless an idle burst follows, so the next call can
    // reuse it without lowering it first. Called at a falling edge and
    // returns at one.
    task automatic send_sample(input logic signed [SpeedW-1:0] req,
                               input logic signed [SpeedW-1:0] meas);
        in_valid       <= 1'b1;
        speed_request  <= req;
        speed_measured <= meas;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // Lets every predicted word come out before the registers change. Each
    // sample yields exactly one word, so an empty prediction store means the
    // pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (words_in_flight != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write, after which the write enable is held low again so
    // that back-to-back writes never change the enable twice in one step.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDatW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Picks a new setting of all five registers. Gains are mostly moderate so
    // that the loop does not simply saturate, with the extremes mixed in.
    // Offset and limit are written with random upper bits, which the block
    // must drop, and now and then with values outside their usual range,
    // including an offset of zero and a limit of one.
    task automatic program_gains();
        logic [CfgDatW-1:0] value;
        logic [DutyW-1:0]   narrow;
        for (int k = REG_GAIN_PROP; k <= REG_GAIN_DERIV; k++)
        begin
            case ($urandom_range(0, 7))
                0:       value = '0;
                1:       value = '1;
                2:       value = CfgDatW'($urandom);
                default: value = CfgDatW'($urandom_range(0, 4096));
            endcase
            write_reg(CfgIdxW'(k), value);
        end
        case ($urandom_range(0, 5))
            0:       narrow = '0;
            1:       narrow = 14'd10000;
            2:       narrow = DutyW'($urandom);
            default: narrow = DutyW'($urandom_range(0, 3000));
        endcase
        write_reg(REG_DRIVE_OFFSET, {2'($urandom), narrow});
        case ($urandom_range(0, 5))
            0:       narrow = 14'd1;
            1:       narrow = '1;
            2:       narrow = DutyW'($urandom);
            default: narrow = DutyW'($urandom_range(2000, 16383));
        endcase
        write_reg(REG_DUTY_LIMIT, {2'($urandom), narrow});
    endtask

    initial
    begin
        int roll;
        int mag;
        int target;
        int motor;
        int jitter;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        speed_request  = '0;
        speed_measured = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_GAIN_PROP;
        cfg_wdata      = '0;
        gap_pct        = 0;
        stall_pct      = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset gains: a plain forward request,
        // the largest errors both ways, the most negative request (which
        // folds to +32768 exactly), a stop that clears the history, and a
        // reverse request with a measured speed of the opposite sign.
        gap_pct   = 20;
        stall_pct = 20;
        send_sample(16'sh6400, 16'sh0000);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh0001, 16'sh7fff);
        send_sample(-16'sh0001, 16'sh8000);
        send_sample(16'sh0000, 16'sh5a5a);
        send_sample(16'sh0100, 16'sh0100);
        send_sample(-16'sh0100, 16'sh7fff);
        settle();

        // All gains at their maximum, offset and limit with every bit set:
        // the drive runs into the upper clamp and then the lower one.
        write_reg(REG_GAIN_PROP, '1);
        write_reg(REG_GAIN_INTEG, '1);
        write_reg(REG_GAIN_DERIV, '1);
        write_reg(REG_DRIVE_OFFSET, '1);
        write_reg(REG_DUTY_LIMIT, '1);
        send_sample(16'sh7fff, 16'sh0000);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(-16'sh7fff, 16'sh7fff);
        settle();

        // Zero gains and offset with a limit of one.
        write_reg(REG_GAIN_PROP, '0);
        write_reg(REG_GAIN_INTEG, '0);
        write_reg(REG_GAIN_DERIV, '0);
        write_reg(REG_DRIVE_OFFSET, '0);
        write_reg(REG_DUTY_LIMIT, 16'd1);
        send_sample(16'sh1234, 16'sh0000);
        send_sample(-16'sh1234, 16'sh4000);
        settle();

        // A limit of zero pins the duty at zero whatever the error.
        write_reg(REG_GAIN_PROP, GainPropReset);
        write_reg(REG_DRIVE_OFFSET, CfgDatW'(DriveOffsetReset));
        write_reg(REG_DUTY_LIMIT, '0);
        send_sample(16'sh2000, 16'sh0000);
        send_sample(-16'sh2000, 16'sh1000);
        settle();

        // Back to the reset setting, then writes to the unused indexes,
        // which must leave every register as it is.
        write_reg(REG_GAIN_INTEG, GainIntegReset);
        write_reg(REG_GAIN_DERIV, GainDerivReset);
        write_reg(REG_DUTY_LIMIT, CfgDatW'(DutyLimitReset));
        for (int k = REG_DUTY_LIMIT + 1; k < (1 << CfgIdxW); k++)
            write_reg(CfgIdxW'(k), '1);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh3000, 16'sh1000);
        send_sample(16'sh3000, 16'sh2800);
        settle();

        // Random part. Most words follow a simple motor that chases its
        // requested speed, so the error history builds up as in real use.
        // The rest are stops, new targets and words with fully random bits.
        target = 16'sh1000;
        motor  = 0;
        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            program_gains();
            if (phase == PhaseCount - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    2:       gap_pct = 30;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 25;
                    default: stall_pct = 50;
                endcase
            end
            for (int n = 0; n < PhaseWords; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                begin
                    motor = 0;
                    send_sample(16'sh0000, SpeedW'($urandom));
                end
                else if (roll < 15)
                begin
                    send_sample(SpeedW'($urandom), SpeedW'($urandom));
                end
                else
                begin
                    if (roll < 20)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            mag = $urandom_range(1, 32767);
                        else
                            mag = $urandom_range(1, 8000);
                        target = ($urandom_range(0, 1) != 0) ? -mag : mag;
                    end
                    jitter = $urandom_range(0, 400);
                    motor  = motor + (target - motor) / 4 + jitter - 200;
                    if (motor > 32767)
                        motor = 32767;
                    if (motor < -32768)
                        motor = -32768;
                    send_sample(target[SpeedW-1:0], motor[SpeedW-1:0]);
                end
            end
            settle();
        end

        // Every word has been taken; wait out the pipeline, then wait DrainCycles
        // more clock periods so that any stray output word shows.
        while (words_in_flight != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: incremental_pid_speed_controller.f
sv/ipsc_pkg.sv
sv/ipsc_datapath.sv
sv/incremental_pid_speed_controller.sv
tb/duty_checker.sv
tb/tb.sv
